// ===== sv/pps_pkg.sv =====
// Shared constants, state codes and helper functions for the point splatter.
// No dependencies; the RTL uses its scoped names and the testbench imports it.
package pps_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH_W    = 32;

	localparam int NUM_W = 62;
	localparam int DEN_W = 39;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
	localparam logic signed [DEN_W-1:0] CULL_RAW = 39'sd6553;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_COS_YAW    = 3'd0;
	localparam logic [2:0] REG_SIN_YAW    = 3'd1;
	localparam logic [2:0] REG_COS_PITCH  = 3'd2;
	localparam logic [2:0] REG_SIN_PITCH  = 3'd3;
	localparam logic [2:0] REG_CAM_DIST   = 3'd4;
	localparam logic [2:0] REG_FOCAL      = 3'd5;
	localparam logic [2:0] REG_FRAME_W    = 3'd6;
	localparam logic [2:0] REG_FRAME_H    = 3'd7;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Sequencer states.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_ROT1 = 4'd1;
	localparam logic [ST_W-1:0] ST_ROT2 = 4'd2;
	localparam logic [ST_W-1:0] ST_CULL = 4'd3;
	localparam logic [ST_W-1:0] ST_PROJ = 4'd4;
	localparam logic [ST_W-1:0] ST_DSX  = 4'd5;
	localparam logic [ST_W-1:0] ST_DIVX = 4'd6;
	localparam logic [ST_W-1:0] ST_DSY  = 4'd7;
	localparam logic [ST_W-1:0] ST_DIVY = 4'd8;
	localparam logic [ST_W-1:0] ST_PIX  = 4'd9;
	localparam logic [ST_W-1:0] ST_RD   = 4'd10;
	localparam logic [ST_W-1:0] ST_CMP  = 4'd11;
	localparam logic [ST_W-1:0] ST_CLR  = 4'd12;

	function automatic logic signed [31:0] sat_s32(input logic signed [37:0] v);
		if (v > 38'sh007FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (v < -38'sh0080000000)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// Final shade: scaled product / 6553600 (base if full), plus 15, saturated.
	function automatic logic [7:0] shade_fin(input logic [30:0] prod, input logic full,
		input logic [7:0] base);
		logic [14:0] a;
		logic [27:0] m;
		logic [8:0]  v;
		a = prod[30:16];
		m = 28'(a) * 28'd5243;
		if (full)
			v = 9'(base) + 9'd15;
		else
			v = 9'(m[27:19]) + 9'd15;
		return (v > 9'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

// ===== sv/pps_if.sv =====
// Valid/ready channel interfaces for input items and result words.
// Depends on nothing but the field widths of the work.
interface pps_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] density;
	logic [7:0]  base_red;
	logic [7:0]  base_green;
	logic [7:0]  base_blue;
	modport source (output valid, kind, pos_x, pos_y, pos_z, density,
		base_red, base_green, base_blue, input ready);
	modport sink (input valid, kind, pos_x, pos_y, pos_z, density,
		base_red, base_green, base_blue, output ready);
endinterface

interface pps_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] pixel_x;
	logic [9:0] pixel_y;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
	modport sink (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

// ===== sv/pps_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on pps_pkg for operand widths.
module pps_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pps_pkg::NUM_W-1:0]    num,
	input  logic [pps_pkg::DEN_W-1:0]    den,
	output logic                         done,
	output logic [pps_pkg::NUM_W-1:0]    quo
);
	localparam int CNT_W = $clog2(pps_pkg::NUM_W + 1);

	logic [pps_pkg::DEN_W:0]   rem_q;
	logic [pps_pkg::NUM_W-1:0] q_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [pps_pkg::DEN_W+1:0] trial;

	assign trial = {rem_q, q_q[pps_pkg::NUM_W-1]} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pps_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[pps_pkg::DEN_W+1]) begin
				rem_q <= trial[pps_pkg::DEN_W:0];
				q_q   <= {q_q[pps_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[pps_pkg::DEN_W-1:0], q_q[pps_pkg::NUM_W-1]};
				q_q   <= {q_q[pps_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

// ===== sv/point_project_zbuffer_splat_top.sv =====
// Point splatter: rotate, cull, project and depth-test one point at a time.
// A point's result word follows the two divides in pps_div (62 quotient steps each) and
// the depth test; the next word is taken only once the point is through, sooner after a
// culled one, and later while the result is stalled. A clear word writes all 1048576
// depth entries, one per cycle; after reset the same pass runs before the first word.
// Config writes land any time. Needs pps_pkg, pps_if, pps_div.
module point_project_zbuffer_splat_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	pps_in_if.sink      in_ch,
	pps_out_if.source   out_ch
);
	// Configuration registers.
	logic signed [15:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
	logic [30:0]        cam_dist_q, focal_q;
	logic [10:0]        frame_w_q, frame_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_yaw_q   <= 16'sd16384;
			sin_yaw_q   <= 16'sd0;
			cos_pitch_q <= 16'sd16384;
			sin_pitch_q <= 16'sd0;
			cam_dist_q  <= 31'd2228224;
			focal_q     <= 31'd14417920;
			frame_w_q   <= 11'd720;
			frame_h_q   <= 11'd720;
		end else if (cfg_we) begin
			case (cfg_index)
				pps_pkg::REG_COS_YAW:   cos_yaw_q   <= cfg_data[15:0];
				pps_pkg::REG_SIN_YAW:   sin_yaw_q   <= cfg_data[15:0];
				pps_pkg::REG_COS_PITCH: cos_pitch_q <= cfg_data[15:0];
				pps_pkg::REG_SIN_PITCH: sin_pitch_q <= cfg_data[15:0];
				pps_pkg::REG_CAM_DIST:  cam_dist_q  <= cfg_data;
				pps_pkg::REG_FOCAL:     focal_q     <= cfg_data;
				pps_pkg::REG_FRAME_W:   frame_w_q   <= cfg_data[10:0];
				pps_pkg::REG_FRAME_H:   frame_h_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic [pps_pkg::ST_W-1:0] state_q;
	logic                     accept;
	assign in_ch.ready = (state_q == pps_pkg::ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Captured item.
	logic signed [31:0] x_q, y_q, z_q;
	logic [31:0]        dens_q;
	logic [7:0]         br_q, bg_q, bb_q;

	// Rotation: yaw gives nx and nz, pitch gives ny and fz. Floor shifts.
	logic signed [48:0] yaw_x, yaw_z;
	logic signed [51:0] pit_y, pit_z;
	logic signed [34:0] nx_q, nz_q;
	logic signed [37:0] ny_q, fz_q;
	assign yaw_x = 49'(x_q) * 49'(cos_yaw_q) - 49'(z_q) * 49'(sin_yaw_q);
	assign yaw_z = 49'(x_q) * 49'(sin_yaw_q) + 49'(z_q) * 49'(cos_yaw_q);
	assign pit_y = 52'(y_q) * 52'(cos_pitch_q) - 52'(nz_q) * 52'(sin_pitch_q);
	assign pit_z = 52'(y_q) * 52'(sin_pitch_q) + 52'(nz_q) * 52'(cos_pitch_q);

	logic signed [pps_pkg::DEN_W-1:0] zq_q;

	// Projection products and their signs.
	logic signed [62:0] mul_x, mul_y;
	logic [pps_pkg::NUM_W-1:0] magx_q, magy_q;
	logic                      negx_q, negy_q;
	assign mul_x = 63'(pps_pkg::sat_s32(38'(nx_q))) * 63'($signed({1'b0, focal_q}));
	assign mul_y = 63'(pps_pkg::sat_s32(ny_q)) * 63'($signed({1'b0, focal_q}));

	// Shared divider.
	logic                      div_start, div_done;
	logic [pps_pkg::NUM_W-1:0] div_num, div_quo;
	assign div_start = (state_q == pps_pkg::ST_DSX) || (state_q == pps_pkg::ST_DSY);
	assign div_num   = (state_q == pps_pkg::ST_DSY) ? magy_q : magx_q;

	pps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (zq_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic signed [63:0] tx_q, ty_q;
	logic signed [63:0] div_signed;
	assign div_signed = ((state_q == pps_pkg::ST_DIVY) ? negy_q : negx_q)
		? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

	// Screen offsets: W*29491.2 and H*27525.12, floored, by reciprocal products.
	logic [26:0] ox, oy;
	logic [24:0] w5, h25;
	assign w5  = 25'(frame_w_q) * 25'd13108;
	assign h25 = 25'(frame_h_q) * 25'd15729;
	assign ox  = 27'(frame_w_q) * 27'd29491 + 27'(w5[24:16]);
	assign oy  = 27'(frame_h_q) * 27'd27525 + 27'(h25[24:17]);

	logic signed [63:0] sum_x, sum_y, px, py;
	assign sum_x = $signed({37'd0, ox}) + tx_q;
	assign sum_y = $signed({37'd0, oy}) - ty_q;
	assign px = (sum_x < 0) ? ((sum_x + 64'sd65535) >>> 16) : (sum_x >>> 16);
	assign py = (sum_y < 0) ? ((sum_y + 64'sd65535) >>> 16) : (sum_y >>> 16);

	logic on_screen;
	assign on_screen = !px[63] && !py[63]
		&& (px < $signed({53'd0, frame_w_q})) && (py < $signed({53'd0, frame_h_q}))
		&& (px < 64'(pps_pkg::MAX_WIDTH)) && (py < 64'(pps_pkg::MAX_HEIGHT));

	logic [pps_pkg::COL_W-1:0] col_q;
	logic [pps_pkg::ROW_W-1:0] row_q;

	// Shading: density*45, then base times that, then the constant divide.
	logic [37:0] d45_q;
	logic        dfull_q;
	logic [30:0] pr_q, pg_q, pb_q;
	logic [7:0]  sr_q, sg_q, sb_q;

	// Depth store, one synchronous memory.
	logic [pps_pkg::DEPTH_W-1:0] depth_mem [0:(1 << pps_pkg::ADDR_W)-1];
	logic [pps_pkg::DEPTH_W-1:0] rdata_q;
	logic                        mem_we;
	logic [pps_pkg::ADDR_W-1:0]  mem_waddr;
	logic [pps_pkg::DEPTH_W-1:0] mem_wdata;
	logic [pps_pkg::ADDR_W:0]    clr_q;
	logic [pps_pkg::DEPTH_W-1:0] zs;
	logic                        nearer, out_free;

	assign zs       = (zq_q > $signed({7'd0, pps_pkg::DEPTH_MAX}))
		? pps_pkg::DEPTH_MAX : zq_q[pps_pkg::DEPTH_W-1:0];
	assign nearer   = zs < rdata_q;
	assign out_free = !out_ch.valid || out_ch.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {row_q, col_q};
		mem_wdata = zs;
		if (state_q == pps_pkg::ST_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q[pps_pkg::ADDR_W-1:0];
			mem_wdata = pps_pkg::DEPTH_MAX;
		end else if (state_q == pps_pkg::ST_CMP && nearer && out_free) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			depth_mem[mem_waddr] <= mem_wdata;
		rdata_q <= depth_mem[{row_q, col_q}];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				pps_pkg::ST_IDLE: begin
					if (accept) begin
						if (in_ch.kind == pps_pkg::KIND_CLEAR) begin
							state_q <= pps_pkg::ST_CLR;
							clr_q   <= '0;
						end else begin
							state_q <= pps_pkg::ST_ROT1;
						end
					end
				end
				pps_pkg::ST_ROT1: state_q <= pps_pkg::ST_ROT2;
				pps_pkg::ST_ROT2: state_q <= pps_pkg::ST_CULL;
				pps_pkg::ST_CULL: state_q <= pps_pkg::ST_PROJ;
				pps_pkg::ST_PROJ: begin
					state_q <= (zq_q <= pps_pkg::CULL_RAW) ? pps_pkg::ST_IDLE : pps_pkg::ST_DSX;
				end
				pps_pkg::ST_DSX:  state_q <= pps_pkg::ST_DIVX;
				pps_pkg::ST_DIVX: if (div_done) state_q <= pps_pkg::ST_DSY;
				pps_pkg::ST_DSY:  state_q <= pps_pkg::ST_DIVY;
				pps_pkg::ST_DIVY: if (div_done) state_q <= pps_pkg::ST_PIX;
				pps_pkg::ST_PIX:  state_q <= on_screen ? pps_pkg::ST_RD : pps_pkg::ST_IDLE;
				pps_pkg::ST_RD:   state_q <= pps_pkg::ST_CMP;
				pps_pkg::ST_CMP: begin
					if (!nearer || out_free)
						state_q <= pps_pkg::ST_IDLE;
				end
				pps_pkg::ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (pps_pkg::ADDR_W+1)'((1 << pps_pkg::ADDR_W) - 1))
						state_q <= pps_pkg::ST_IDLE;
				end
				default: state_q <= pps_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded as the sequencer passes each step.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_ch.pos_x;
			y_q    <= in_ch.pos_y;
			z_q    <= in_ch.pos_z;
			dens_q <= in_ch.density;
			br_q   <= in_ch.base_red;
			bg_q   <= in_ch.base_green;
			bb_q   <= in_ch.base_blue;
		end
		if (state_q == pps_pkg::ST_ROT1) begin
			nx_q    <= 35'(yaw_x >>> 14);
			nz_q    <= 35'(yaw_z >>> 14);
			d45_q   <= 38'(dens_q) * 38'd45;
		end
		if (state_q == pps_pkg::ST_ROT2) begin
			ny_q    <= 38'(pit_y >>> 14);
			fz_q    <= 38'(pit_z >>> 14);
			dfull_q <= d45_q >= 38'd6553600;
		end
		if (state_q == pps_pkg::ST_CULL) begin
			zq_q <= 39'(fz_q) + $signed({8'd0, cam_dist_q});
			pr_q <= 31'(br_q) * 31'(d45_q[22:0]);
			pg_q <= 31'(bg_q) * 31'(d45_q[22:0]);
			pb_q <= 31'(bb_q) * 31'(d45_q[22:0]);
		end
		if (state_q == pps_pkg::ST_PROJ) begin
			negx_q <= mul_x[62];
			negy_q <= mul_y[62];
			magx_q <= mul_x[62] ? 62'(-mul_x) : mul_x[61:0];
			magy_q <= mul_y[62] ? 62'(-mul_y) : mul_y[61:0];
			sr_q   <= pps_pkg::shade_fin(pr_q, dfull_q, br_q);
			sg_q   <= pps_pkg::shade_fin(pg_q, dfull_q, bg_q);
			sb_q   <= pps_pkg::shade_fin(pb_q, dfull_q, bb_q);
		end
		if (state_q == pps_pkg::ST_DIVX && div_done)
			tx_q <= div_signed;
		if (state_q == pps_pkg::ST_DIVY && div_done)
			ty_q <= div_signed;
		if (state_q == pps_pkg::ST_PIX) begin
			col_q <= px[pps_pkg::COL_W-1:0];
			row_q <= py[pps_pkg::ROW_W-1:0];
		end
	end

	// Result register: holds a word until the sink takes it.
	logic       ov_q;
	logic [9:0] opx_q, opy_q;
	logic [7:0] or_q, og_q, ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == pps_pkg::ST_CMP && nearer && out_free) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::ST_CMP && nearer && out_free) begin
			opx_q <= 10'(col_q);
			opy_q <= 10'(row_q);
			or_q  <= sr_q;
			og_q  <= sg_q;
			ob_q  <= sb_q;
		end
	end

	assign out_ch.valid   = ov_q;
	assign out_ch.pixel_x = opx_q;
	assign out_ch.pixel_y = opy_q;
	assign out_ch.red     = or_q;
	assign out_ch.green   = og_q;
	assign out_ch.blue    = ob_q;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for point_project_zbuffer_splat_top: a directed table, then
// random points under several camera settings, predicted in SystemVerilog and compared.
// Depends on pps_pkg, pps_if and the RTL of the point splatter.
module tb_top;

	import pps_pkg::*;

	// One input word: a point to splat or a request to clear the depth store.
	typedef struct packed {
		logic        kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] density;
		logic [7:0]  base_red;
		logic [7:0]  base_green;
		logic [7:0]  base_blue;
	} point_word_t;

	// One output word: a shaded pixel that won the depth test.
	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// A row of the directed table. When typed is set, the expected outcome is written
	// into the row itself; otherwise the predictor decides it.
	typedef struct {
		point_word_t word;
		bit          typed;
		bit          hit;
		pixel_t      pix;
	} splat_row_t;

	localparam int  IDLE_PAUSE   = 200;        // a bit more than one point's latency
	localparam int  WATCHDOG_MAX = 3_000_000;  // covers a full clearing pass several times
	localparam int  ITEMS_PER_PH = 125;
	localparam int  NUM_PHASES   = 8;
	localparam longint ZMAX      = 64'h0000_0000_FFFF_FFFF;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] CAM_Z = 32'd2228224;  // default camera distance, 34.0

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_data;

	pps_in_if  in_ch();
	pps_out_if out_ch();

	point_project_zbuffer_splat_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow copy of the camera registers, kept at the widths the block uses.
	longint cam_cos_yaw, cam_sin_yaw, cam_cos_pitch, cam_sin_pitch;
	longint cam_dist, cam_focal, cam_width, cam_height;

	// Shadow depth store. Entries absent from the map hold the cleared value, so a
	// clear is simply an empty map.
	logic [31:0] depth_mem [int];

	pixel_t pixel_q[$];   // pixels still owed by the block, oldest first
	int     fail_count;
	bit     src_burst;    // sender runs back to back while set
	bit     sink_burst;   // receiver never stalls while set
	int     sink_stall;
	int     quiet_cycles;

	always #5 clk = ~clk;

	function automatic logic [7:0] shade_channel(longint unsigned base,
		longint unsigned dens);
		longint unsigned v;
		if (dens * 45 >= 64'd6553600)
			v = base + 15;
		else
			v = (base * dens * 45) / 64'd6553600 + 15;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Runs one word through the shadow pipeline. Returns 1 when the block owes a pixel,
	// and updates the shadow depth store the same way the block does.
	function automatic bit predict_splat(point_word_t w, output pixel_t pix);
		longint x, y, z, nx, nz, ny, fz, zq, tx, ty, px, py, zs;
		int idx;
		logic [31:0] stored;
		pix = '0;
		if (w.kind == KIND_CLEAR) begin
			depth_mem.delete();
			return 0;
		end
		x = longint'($signed(w.pos_x));
		y = longint'($signed(w.pos_y));
		z = longint'($signed(w.pos_z));
		// Arithmetic shift on a signed value rounds toward minus infinity.
		nx = (x * cam_cos_yaw - z * cam_sin_yaw) >>> 14;
		nz = (x * cam_sin_yaw + z * cam_cos_yaw) >>> 14;
		ny = (y * cam_cos_pitch - nz * cam_sin_pitch) >>> 14;
		fz = (y * cam_sin_pitch + nz * cam_cos_pitch) >>> 14;
		zq = fz + cam_dist;
		if (zq <= 6553)
			return 0;
		tx = (clamp_s32(nx) * cam_focal) / zq;
		ty = (clamp_s32(ny) * cam_focal) / zq;
		px = ((cam_width * 2949120) / 100 + tx) / 65536;
		py = ((cam_height * 2752512) / 100 - ty) / 65536;
		if (px < 0 || py < 0 || px >= cam_width || py >= cam_height ||
			px >= MAX_WIDTH || py >= MAX_HEIGHT)
			return 0;
		idx = int'(py) * MAX_WIDTH + int'(px);
		zs = (zq > ZMAX) ? ZMAX : zq;
		stored = depth_mem.exists(idx) ? depth_mem[idx] : DEPTH_MAX;
		if (zs >= longint'(stored))
			return 0;
		depth_mem[idx] = zs[31:0];
		pix.pixel_x = px[9:0];
		pix.pixel_y = py[9:0];
		pix.red     = shade_channel(w.base_red, w.density);
		pix.green   = shade_channel(w.base_green, w.density);
		pix.blue    = shade_channel(w.base_blue, w.density);
		return 1;
	endfunction

	// Writes one camera register and mirrors it into the shadow copy. The caller drops
	// the write enable after the last write of a group.
	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_COS_YAW:   cam_cos_yaw   = longint'($signed(val[15:0]));
			REG_SIN_YAW:   cam_sin_yaw   = longint'($signed(val[15:0]));
			REG_COS_PITCH: cam_cos_pitch = longint'($signed(val[15:0]));
			REG_SIN_PITCH: cam_sin_pitch = longint'($signed(val[15:0]));
			REG_CAM_DIST:  cam_dist      = longint'(val);
			REG_FOCAL:     cam_focal     = longint'(val);
			REG_FRAME_W:   cam_width     = longint'(val[10:0]);
			default:       cam_height    = longint'(val[10:0]);
		endcase
		@(posedge clk);
	endtask

	task automatic set_camera(int cy, int sy, int cp, int sp, logic [30:0] dist_val,
		logic [30:0] focal, logic [10:0] w, logic [10:0] h);
		write_reg(REG_COS_YAW, 31'(cy));
		write_reg(REG_SIN_YAW, 31'(sy));
		write_reg(REG_COS_PITCH, 31'(cp));
		write_reg(REG_SIN_PITCH, 31'(sp));
		write_reg(REG_CAM_DIST, dist_val);
		write_reg(REG_FOCAL, focal);
		write_reg(REG_FRAME_W, 31'(w));
		write_reg(REG_FRAME_H, 31'(h));
		cfg_we <= 1'b0;
	endtask

	// Waits until every owed pixel has come, then lets a culled or dropped point that
	// produces nothing drain out of the pipeline before the camera changes.
	task automatic drain_pipeline();
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// Presents one word and returns at the edge where it is taken. Valid is only
	// lowered when a gap is drawn, so back-to-back words keep it high.
	task automatic send_word(point_word_t w);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_burst = ~src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= w.kind;
		in_ch.pos_x      <= w.pos_x;
		in_ch.pos_y      <= w.pos_y;
		in_ch.pos_z      <= w.pos_z;
		in_ch.density    <= w.density;
		in_ch.base_red   <= w.base_red;
		in_ch.base_green <= w.base_green;
		in_ch.base_blue  <= w.base_blue;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// Sends a word and records what the block now owes for it.
	task automatic splat(point_word_t w);
		pixel_t pix;
		send_word(w);
		if (predict_splat(w, pix))
			pixel_q.push_back(pix);
	endtask

	// Draws a random word. Most are points near the camera axis, at a random scale, so
	// that they land on screen; some are full range, and some revisit the last point
	// at a slightly different depth to work the depth test.
	function automatic point_word_t random_point(point_word_t last);
		point_word_t w;
		int sh;
		int mode;
		w.kind       = KIND_POINT;
		w.base_red   = $urandom;
		w.base_green = $urandom;
		w.base_blue  = $urandom;
		w.density    = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 150000);
		mode = $urandom_range(0, 19);
		if (mode < 3) begin
			w.pos_x = $urandom;
			w.pos_y = $urandom;
			w.pos_z = $urandom;
		end else if (mode < 7 && last.kind == KIND_POINT) begin
			w.pos_x = last.pos_x;
			w.pos_y = last.pos_y;
			w.pos_z = last.pos_z + 32'($signed($urandom_range(0, 8192)) - 4096);
		end else begin
			sh = $urandom_range(8, 22);
			w.pos_x = 32'($signed($urandom_range(0, 2 << sh)) - (1 << sh));
			w.pos_y = 32'($signed($urandom_range(0, 2 << sh)) - (1 << sh));
			w.pos_z = 32'($signed($urandom_range(0, 2 << sh)) - (1 << sh));
		end
		return w;
	endfunction

	function automatic int random_trig();
		return $urandom_range(0, 32768) - 16384;
	endfunction

	// Receiver: stalls a random number of cycles after each word, or none during bursts,
	// and checks every word it takes against the oldest owed pixel.
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		int draw;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_stall   <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pixel_q.size() == 0) begin
					$error("pixel word with none owed: x %0d y %0d", out_ch.pixel_x,
						out_ch.pixel_y);
					fail_count++;
				end else begin
					want = pixel_q.pop_front();
					if (out_ch.pixel_x !== want.pixel_x) begin
						$error("pixel_x mismatch: expected %0d, actual %0d",
							want.pixel_x, out_ch.pixel_x);
						fail_count++;
					end
					if (out_ch.pixel_y !== want.pixel_y) begin
						$error("pixel_y mismatch: expected %0d, actual %0d",
							want.pixel_y, out_ch.pixel_y);
						fail_count++;
					end
					if (out_ch.red !== want.red) begin
						$error("red mismatch: expected %0d, actual %0d", want.red, out_ch.red);
						fail_count++;
					end
					if (out_ch.green !== want.green) begin
						$error("green mismatch: expected %0d, actual %0d", want.green,
							out_ch.green);
						fail_count++;
					end
					if (out_ch.blue !== want.blue) begin
						$error("blue mismatch: expected %0d, actual %0d", want.blue,
							out_ch.blue);
						fail_count++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					sink_burst = ~sink_burst;
				draw = sink_burst ? 0 : $urandom_range(0, 18);
				sink_stall   <= draw;
				out_ch.ready <= (draw == 0);
			end else if (sink_stall > 0) begin
				sink_stall   <= sink_stall - 1;
				out_ch.ready <= (sink_stall == 1);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a long stretch with no word taken on either side means a hang. A clear
	// legitimately blocks the input while it rewrites every depth entry, so the limit is
	// well above a full clearing pass.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		splat_row_t  rows[$];
		splat_row_t  r;
		point_word_t w;
		point_word_t last;
		pixel_t      pix;
		bit          hit;

		clk          = 1'b0;
		arst_n       = 1'b0;
		fail_count   = 0;
		quiet_cycles = 0;
		src_burst    = 1'b0;
		sink_burst   = 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_COS_YAW;
		cfg_data         <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.kind       <= KIND_POINT;
		in_ch.pos_x      <= '0;
		in_ch.pos_y      <= '0;
		in_ch.pos_z      <= '0;
		in_ch.density    <= '0;
		in_ch.base_red   <= '0;
		in_ch.base_green <= '0;
		in_ch.base_blue  <= '0;

		// Reset values of the camera registers.
		cam_cos_yaw   = 16384;
		cam_sin_yaw   = 0;
		cam_cos_pitch = 16384;
		cam_sin_pitch = 0;
		cam_dist      = 2228224;
		cam_focal     = 14417920;
		cam_width     = 720;
		cam_height    = 720;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, run with the reset camera: distance 34, focal 220, a 720 by
		// 720 frame. The origin lands on column 324, row 302.
		r = '{word: '0, typed: 1, hit: 1, pix: '0};
		r.word.kind = KIND_POINT;
		r.word.base_red = 8'd0; r.word.base_green = 8'd128; r.word.base_blue = 8'd255;
		r.pix = '{10'd324, 10'd302, 8'd15, 8'd15, 8'd15};
		rows.push_back(r);                      // zero density shades to the floor
		r.hit = 0;
		rows.push_back(r);                      // same depth again is not nearer
		r.word.pos_z = -Q_ONE;
		r.word.density = 32'hFFFF_FFFF;
		r.hit = 1;
		r.pix = '{10'd324, 10'd302, 8'd15, 8'd143, 8'd255};
		rows.push_back(r);                      // full density, blue saturates
		r.word.pos_z = -CAM_Z;
		r.hit = 0;
		rows.push_back(r);                      // depth zero is culled
		r.word.pos_z = -CAM_Z + 32'd6553;
		rows.push_back(r);                      // depth exactly at the cull limit
		r.word.pos_z = -CAM_Z + 32'd6554;
		r.word.density = Q_ONE;
		r.word.base_red = 8'd10; r.word.base_green = 8'd20; r.word.base_blue = 8'd30;
		r.hit = 1;
		r.pix = '{10'd324, 10'd302, 8'd19, 8'd24, 8'd28};
		rows.push_back(r);                      // just past the cull limit, partial shade
		r.word.pos_z = 32'h7FFF_FFFF;
		r.hit = 0;
		rows.push_back(r);                      // far point behind the stored depth
		r.word.pos_z = '0;
		r.word.pos_x = 32'h7FFF_FFFF;
		rows.push_back(r);                      // off the right edge
		r.word.pos_x = 32'h8000_0000;
		rows.push_back(r);                      // off the left edge
		r.word.pos_x = '0;
		r.word.pos_y = 32'h7FFF_FFFF;
		rows.push_back(r);                      // above the frame
		r.word.pos_y = 32'h8000_0000;
		rows.push_back(r);                      // below the frame
		r.typed = 0;
		r.word.pos_y = '0;
		r.word.pos_x = -32'sd3286203;
		rows.push_back(r);                      // column in (-1,0) truncates to zero
		r.word.pos_x = 32'sd3286203;
		rows.push_back(r);
		r.word.pos_x = 32'sd655360;
		r.word.pos_y = -32'sd983040;
		r.word.pos_z = 32'sd196608;
		r.word.density = 32'h0000_FFFF;
		r.word.base_red = 8'hFF; r.word.base_green = 8'h55; r.word.base_blue = 8'hAA;
		rows.push_back(r);
		r.word.pos_y = 32'sd983040;
		r.word.density = 32'h0002_3A2E;         // near the point where shading saturates
		rows.push_back(r);
		r.word = '{kind: KIND_CLEAR, pos_x: 32'hFFFF_FFFF, pos_y: 32'hFFFF_FFFF,
			pos_z: 32'hFFFF_FFFF, density: 32'hFFFF_FFFF, base_red: 8'hFF,
			base_green: 8'hFF, base_blue: 8'hFF};
		r.typed = 1;
		r.hit = 0;
		rows.push_back(r);                      // clear yields nothing
		r.typed = 0;
		r.word = '0;
		r.word.kind = KIND_POINT;
		r.word.pos_z = 32'h7FFF_FFFF;
		r.word.density = 32'h0000_8000;
		r.word.base_red = 8'd200; r.word.base_green = 8'd1; r.word.base_blue = 8'd77;
		rows.push_back(r);                      // the far point now beats a cleared entry

		foreach (rows[i]) begin
			send_word(rows[i].word);
			hit = predict_splat(rows[i].word, pix);
			if (rows[i].typed) begin
				if (rows[i].hit)
					pixel_q.push_back(rows[i].pix);
			end else if (hit) begin
				pixel_q.push_back(pix);
			end
		end
		last = rows[rows.size() - 1].word;

		// Random part: each phase sets the camera while the block is idle, then streams
		// points. The early phases hit the register extremes.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			in_ch.valid <= 1'b0;
			drain_pipeline();
			case (ph)
				0: set_camera(16384, 0, 16384, 0, 31'd2228224, 31'd14417920,
					11'd720, 11'd720);
				1: set_camera(-16384, 16384, -16384, 16384, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
					11'd1024, 11'd1024);
				// Strong yaw and a far camera push depths past 32 bits, so saturated
				// depths meet a store that still holds cleared entries.
				2: set_camera(16384, 16384, 16384, 0, 31'h7FFF_FFFF, 31'd14417920,
					11'd2047, 11'd2047);
				3: set_camera(16384, -16384, 16384, -16384, 31'd0, 31'd0, 11'd1, 11'd1);
				4: set_camera(random_trig(), random_trig(), random_trig(), random_trig(),
					31'd2228224, 31'h7FFF_FFFF, 11'd0, 11'd512);
				default: set_camera(random_trig(), random_trig(), random_trig(),
					random_trig(), 31'($urandom_range(65536, 8388608)),
					31'($urandom_range(1048576, 67108864)),
					11'($urandom_range(16, 1024)), 11'($urandom_range(16, 1024)));
			endcase
			for (int n = 0; n < ITEMS_PER_PH; n++) begin
				w = random_point(last);
				splat(w);
				last = w;
			end
		end

		in_ch.valid <= 1'b0;
		drain_pipeline();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pps_pkg.sv
sv/pps_if.sv
sv/pps_div.sv
sv/point_project_zbuffer_splat_top.sv
tb/tb_top.sv
